FILE: hw/rtl/assert_macros.svh
// Assertion helpers for the queue core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SWAQ_ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("swaq assertion failed");
`define SWAQ_ASSERT(label, prop) `SWAQ_ASSERT_CLK(label, clk_i, rst_ni, prop)
`else
`define SWAQ_ASSERT_CLK(label, clk, rst_n, prop)
`define SWAQ_ASSERT(label, prop)
`endif
`endif

FILE: hw/rtl/swaq_pkg.sv
package swaq_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int ENTRY_W  = 2 * DATA_W;
  localparam int OP_W     = 3;
  localparam int MODE_W   = 2;
  localparam int ERR_W    = 2;

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

  // fold operators
  localparam logic [OP_W-1:0] OP_ADD = 3'd0;
  localparam logic [OP_W-1:0] OP_MIN = 3'd1;
  localparam logic [OP_W-1:0] OP_MAX = 3'd2;
  localparam logic [OP_W-1:0] OP_AND = 3'd3;
  localparam logic [OP_W-1:0] OP_OR  = 3'd4;
  localparam logic [OP_W-1:0] OP_XOR = 3'd5;

  // command modes
  localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

  // error codes
  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

  // one stack entry: element and its running fold
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] fold;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] fold;
    logic [DATA_W-1:0] oldest;
    logic [CNT_W-1:0]  count;
    logic              empty;
    logic [ERR_W-1:0]  err;
  } result_t;

  // associative operator; unused codes fall back to add
  function automatic logic [DATA_W-1:0] combine(input logic [OP_W-1:0] op,
                                                input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] r;
    unique case (op)
      OP_MIN:  r = (a < b) ? a : b;
      OP_MAX:  r = (a > b) ? a : b;
      OP_AND:  r = a & b;
      OP_OR:   r = a | b;
      OP_XOR:  r = a ^ b;
      default: r = a + b;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/swaq_ram.sv
module swaq_ram #(
  parameter int DATA_W = 64,
  parameter int ADDR_W = 8
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/swaq_ctrl.sv
module swaq_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [swaq_pkg::MODE_W-1:0]  mode_i,
  input  logic [swaq_pkg::DATA_W-1:0]  value_i,
  input  logic [swaq_pkg::OP_W-1:0]    op_i,
  output logic                         busy_o,
  output swaq_pkg::mem_req_t           back_req_o,
  input  swaq_pkg::entry_t             back_rdata_i,
  output swaq_pkg::mem_req_t           front_req_o,
  input  swaq_pkg::entry_t             front_rdata_i,
  output swaq_pkg::result_t            res_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EXEC   = 5'b00010,
    ST_XFER   = 5'b00100,
    ST_LOAD   = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [swaq_pkg::CNT_W-1:0]  bd_q, bd_d, fd_q, fd_d;
  logic [swaq_pkg::MODE_W-1:0] mode_q, mode_d;
  logic [swaq_pkg::DATA_W-1:0] value_q, value_d;
  logic [swaq_pkg::ERR_W-1:0]  err_q, err_d;

  // cached tops so the status needs no memory read
  logic [swaq_pkg::DATA_W-1:0] back_top_fold_q, back_top_fold_d;
  logic [swaq_pkg::DATA_W-1:0] back_bottom_q, back_bottom_d;
  logic [swaq_pkg::DATA_W-1:0] front_top_val_q, front_top_val_d;
  logic [swaq_pkg::DATA_W-1:0] front_top_sfx_q, front_top_sfx_d;

  // stack transfer
  logic [swaq_pkg::IDX_W-1:0]  rd_idx_q, rd_idx_d;
  logic [swaq_pkg::IDX_W-1:0]  wr_idx_q, wr_idx_d;
  logic [swaq_pkg::IDX_W-1:0]  xfer_last_q, xfer_last_d;
  logic                        rd_vld_q, rd_vld_d;
  logic [swaq_pkg::DATA_W-1:0] sfx_prev_q, sfx_prev_d;

  logic [swaq_pkg::CNT_W-1:0]  count;
  logic [swaq_pkg::CNT_W-1:0]  bd_m1, fd_m1, fd_m2;
  logic [swaq_pkg::DATA_W-1:0] push_fold, xfer_sfx;

  assign count     = bd_q + fd_q;
  assign bd_m1     = bd_q - swaq_pkg::CNT_W'(1);
  assign fd_m1     = fd_q - swaq_pkg::CNT_W'(1);
  assign fd_m2     = fd_q - swaq_pkg::CNT_W'(2);
  assign push_fold = (bd_q != '0) ? swaq_pkg::combine(op_i, back_top_fold_q, value_q)
                                  : value_q;
  assign xfer_sfx  = (wr_idx_q == '0) ? back_rdata_i.value
                   : swaq_pkg::combine(op_i, back_rdata_i.value, sfx_prev_q);
  assign busy_o    = (state_q != ST_IDLE);

  always_comb begin
    state_d         = state_q;
    bd_d            = bd_q;
    fd_d            = fd_q;
    mode_d          = mode_q;
    value_d         = value_q;
    err_d           = err_q;
    back_top_fold_d = back_top_fold_q;
    back_bottom_d   = back_bottom_q;
    front_top_val_d = front_top_val_q;
    front_top_sfx_d = front_top_sfx_q;
    rd_idx_d        = rd_idx_q;
    wr_idx_d        = wr_idx_q;
    xfer_last_d     = xfer_last_q;
    rd_vld_d        = rd_vld_q;
    sfx_prev_d      = sfx_prev_q;
    back_req_o      = '0;
    front_req_o     = '0;
    res_o           = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          mode_d  = mode_i;
          value_d = value_i;
          err_d   = swaq_pkg::ERR_OK;
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_d = ST_FINISH;
        if (mode_q == swaq_pkg::MODE_PUSH) begin
          if (count == swaq_pkg::FULL_COUNT) begin
            err_d = swaq_pkg::ERR_FULL;
          end else begin
            back_req_o.we          = 1'b1;
            back_req_o.waddr       = bd_q[swaq_pkg::IDX_W-1:0];
            back_req_o.wdata.value = value_q;
            back_req_o.wdata.fold  = push_fold;
            back_top_fold_d        = push_fold;
            if (bd_q == '0) begin
              back_bottom_d = value_q;
            end
            bd_d = bd_q + swaq_pkg::CNT_W'(1);
          end
        end else if (mode_q == swaq_pkg::MODE_POP) begin
          if (count == '0) begin
            err_d = swaq_pkg::ERR_EMPTY;
          end else if (fd_q == '0) begin
            // front empty: start reading the back stack from its top
            back_req_o.re = 1'b1;
            back_req_o.raddr = bd_m1[swaq_pkg::IDX_W-1:0];
            rd_idx_d    = bd_m1[swaq_pkg::IDX_W-1:0];
            xfer_last_d = bd_m1[swaq_pkg::IDX_W-1:0];
            wr_idx_d    = '0;
            rd_vld_d    = 1'b1;
            state_d     = ST_XFER;
          end else begin
            fd_d = fd_m1;
            if (fd_q > swaq_pkg::CNT_W'(1)) begin
              // fetch the new front top; written in an earlier cycle
              front_req_o.re    = 1'b1;
              front_req_o.raddr = fd_m2[swaq_pkg::IDX_W-1:0];
              state_d           = ST_LOAD;
            end
          end
        end
      end

      ST_XFER: begin
        if (rd_idx_q != '0) begin
          back_req_o.re    = 1'b1;
          back_req_o.raddr = rd_idx_q - swaq_pkg::IDX_W'(1);
          rd_idx_d         = rd_idx_q - swaq_pkg::IDX_W'(1);
          rd_vld_d         = 1'b1;
        end else begin
          rd_vld_d = 1'b0;
        end
        if (rd_vld_q) begin
          front_req_o.we          = 1'b1;
          front_req_o.waddr       = wr_idx_q;
          front_req_o.wdata.value = back_rdata_i.value;
          front_req_o.wdata.fold  = xfer_sfx;
          sfx_prev_d              = xfer_sfx;
          wr_idx_d                = wr_idx_q + swaq_pkg::IDX_W'(1);
          if (wr_idx_q == xfer_last_q) begin
            front_top_val_d = back_rdata_i.value;
            front_top_sfx_d = xfer_sfx;
            fd_d            = swaq_pkg::CNT_W'(xfer_last_q) + swaq_pkg::CNT_W'(1);
            bd_d            = '0;
            state_d         = ST_EXEC;
          end
        end
      end

      ST_LOAD: begin
        front_top_val_d = front_rdata_i.value;
        front_top_sfx_d = front_rdata_i.fold;
        state_d         = ST_FINISH;
      end

      ST_FINISH: begin
        res_o.valid = 1'b1;
        res_o.count = count;
        res_o.empty = (count == '0);
        res_o.err   = err_q;
        if (fd_q != '0 && bd_q != '0) begin
          res_o.fold = swaq_pkg::combine(op_i, front_top_sfx_q, back_top_fold_q);
        end else if (fd_q != '0) begin
          res_o.fold = front_top_sfx_q;
        end else if (bd_q != '0) begin
          res_o.fold = back_top_fold_q;
        end
        if (fd_q != '0) begin
          res_o.oldest = front_top_val_q;
        end else if (bd_q != '0) begin
          res_o.oldest = back_bottom_q;
        end
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bd_q        <= '0;
      fd_q        <= '0;
      rd_idx_q    <= '0;
      wr_idx_q    <= '0;
      xfer_last_q <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      bd_q        <= bd_d;
      fd_q        <= fd_d;
      rd_idx_q    <= rd_idx_d;
      wr_idx_q    <= wr_idx_d;
      xfer_last_q <= xfer_last_d;
      rd_vld_q    <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q          <= mode_d;
    value_q         <= value_d;
    err_q           <= err_d;
    back_top_fold_q <= back_top_fold_d;
    back_bottom_q   <= back_bottom_d;
    front_top_val_q <= front_top_val_d;
    front_top_sfx_q <= front_top_sfx_d;
    sfx_prev_q      <= sfx_prev_d;
  end

endmodule

FILE: hw/rtl/sliding_window_aggregation_queue_core.sv
// Sequence: a command passes the exec and finish states and then the result register; a pop
//   with more than one front entry also passes a load state; with an empty front stack a pop
//   first moves the back stack, one entry per cycle from the back RAM into the front RAM.
// Commands are taken one at a time: busy_o drops in the result cycle, and done_o cannot be
//   held off by the receiver.
// Reset: asynchronous, active low; clears depths, state and operator; RAMs are not cleared.
`include "assert_macros.svh"

module sliding_window_aggregation_queue_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [swaq_pkg::OP_W-1:0]    cfg_wdata_i,
  // command
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [swaq_pkg::MODE_W-1:0]  mode_i,
  input  logic [swaq_pkg::DATA_W-1:0]  value_i,
  // result
  output logic                         done_o,
  output logic [swaq_pkg::DATA_W-1:0]  fold_result_o,
  output logic [swaq_pkg::DATA_W-1:0]  oldest_value_o,
  output logic [swaq_pkg::CNT_W-1:0]   entry_count_o,
  output logic                         is_empty_o,
  output logic [swaq_pkg::ERR_W-1:0]   error_code_o
);

  // operator select; only written while idle (user's duty, not enforced), so stored folds keep their own operator
  logic [swaq_pkg::OP_W-1:0] op_q;

  swaq_pkg::mem_req_t back_req, front_req;
  swaq_pkg::entry_t   back_rdata, front_rdata;
  swaq_pkg::result_t  res;

  // result register: the controller presents the status for one cycle in its
  // finish state, we hold it here as the one-cycle transfer on the ports
  logic                        done_q;
  logic [swaq_pkg::DATA_W-1:0] fold_q, oldest_q;
  logic [swaq_pkg::CNT_W-1:0]  count_q;
  logic                        empty_q;
  logic [swaq_pkg::ERR_W-1:0]  err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q   <= swaq_pkg::OP_ADD;
      done_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        op_q <= cfg_wdata_i;
      end
      done_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      fold_q   <= res.fold;
      oldest_q <= res.oldest;
      count_q  <= res.count;
      empty_q  <= res.empty;
      err_q    <= res.err;
    end
  end

  // sequencer: push/pop/query, stack transfer, tops kept in registers
  swaq_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .mode_i        (mode_i),
    .value_i       (value_i),
    .op_i          (op_q),
    .busy_o        (busy_o),
    .back_req_o    (back_req),
    .back_rdata_i  (back_rdata),
    .front_req_o   (front_req),
    .front_rdata_i (front_rdata),
    .res_o         (res)
  );

  // back stack: element and prefix fold per entry
  swaq_ram #(
    .DATA_W (swaq_pkg::ENTRY_W),
    .ADDR_W (swaq_pkg::IDX_W)
  ) u_back_ram (
    .clk_i   (clk_i),
    .we_i    (back_req.we),
    .waddr_i (back_req.waddr),
    .wdata_i (back_req.wdata),
    .re_i    (back_req.re),
    .raddr_i (back_req.raddr),
    .rdata_o (back_rdata)
  );

  // front stack: element and suffix fold per entry, oldest at the top
  swaq_ram #(
    .DATA_W (swaq_pkg::ENTRY_W),
    .ADDR_W (swaq_pkg::IDX_W)
  ) u_front_ram (
    .clk_i   (clk_i),
    .we_i    (front_req.we),
    .waddr_i (front_req.waddr),
    .wdata_i (front_req.wdata),
    .re_i    (front_req.re),
    .raddr_i (front_req.raddr),
    .rdata_o (front_rdata)
  );

  assign done_o         = done_q;
  assign fold_result_o  = fold_q;
  assign oldest_value_o = oldest_q;
  assign entry_count_o  = count_q;
  assign is_empty_o     = empty_q;
  assign error_code_o   = err_q;

  // results never come back to back: each command passes exec and finish
  `SWAQ_ASSERT(a_done_single, done_o |=> !done_o)
  // an accepted command keeps the block busy in the following cycle
  `SWAQ_ASSERT(a_accept_busy, (start_i && !busy_o) |=> busy_o)
  // an empty queue reports zero fold and zero front
  `SWAQ_ASSERT(a_empty_zero, (done_o && is_empty_o) |-> (fold_result_o == '0 && oldest_value_o == '0))
  // a dropped push only happens at full capacity
  `SWAQ_ASSERT(a_full_count, (done_o && error_code_o == swaq_pkg::ERR_FULL) |-> (entry_count_o == swaq_pkg::FULL_COUNT))

endmodule
